FILE: rtl/pqs_pkg.sv
// Shared constants and field widths for the priority queue scheduler.
package pqs_pkg;

   // Default number of queue entries
   localparam int QUEUE_DEPTH_DEF = 64;

   // Field widths
   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 8;
   localparam int ENTRY_W = VALUE_W + PRIO_W;

   // Operation codes carried on req_tuser
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Status codes carried on rsp_tuser
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

FILE: rtl/pqs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pqs_ram #(
   parameter int WIDTH = pqs_pkg::ENTRY_W,
   parameter int DEPTH = pqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/priority_queue_scheduler_core.sv
// Top level of the bounded priority queue scheduler with linear-scan dequeue.
//
// Entries are kept in one RAM in arrival order. An enqueue item is answered in
// the cycle after it is accepted. A dequeue item walks the stored entries
// through the RAM's single read port, one per cycle, with one shared priority
// comparator (a later equal priority wins), then moves every entry behind the
// winner down by one slot, one per cycle, reading ahead of the write. Enqueue
// on a full queue or dequeue on an empty queue is answered at once with a
// status and changes nothing. One item is worked on at a time; req_tready is
// high while the block is idle and its result register is free or being
// drained.
module priority_queue_scheduler_core #(
   parameter int QUEUE_DEPTH = pqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] item_value, [39:32] item_priority
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] out_value, [39:32] out_priority
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int VW = pqs_pkg::VALUE_W;
   localparam int PW = pqs_pkg::PRIO_W;
   localparam int EW = pqs_pkg::ENTRY_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_SHIFT = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            pend_ff, pend_in;
   logic [CW-1:0]   best_idx_ff, best_idx_in;
   logic [PW-1:0]   best_prio_ff, best_prio_in;
   logic [VW-1:0]   best_val_ff, best_val_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]   rsp_value_ff, rsp_value_in;
   logic [PW-1:0]   rsp_prio_ff, rsp_prio_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [EW-1:0]   wr_data;
   logic [AW-1:0]   rd_addr;
   logic [EW-1:0]   rd_data;

   logic            accept;
   logic            full;
   logic [CW-1:0]   last_idx;
   logic [PW-1:0]   rd_prio;
   logic [VW-1:0]   rd_value;
   logic            take;

   pqs_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign last_idx   = count_ff - CW'(1);
   assign rd_value   = rd_data[VW-1:0];
   assign rd_prio    = rd_data[EW-1:VW];

   // Shared comparator: a later entry of equal priority wins
   assign take = (idx_ff == '0) || (rd_prio >= best_prio_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_val_in   = best_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = {req_tdata[EW-1:VW], req_tdata[VW-1:0]};
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_value_in = '0;
               rsp_prio_in  = '0;
               if (req_tuser == pqs_pkg::OP_ENQUEUE) begin
                  // Append at the back unless full
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_status_in = pqs_pkg::STATUS_FULL;
                  end else begin
                     rsp_status_in = pqs_pkg::STATUS_OK;
                     wr_en         = 1'b1;
                     count_in      = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = pqs_pkg::STATUS_EMPTY;
               end else begin
                  // Start the scan; slot 0 is read now
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = AW'(idx_ff + CW'(1));
            if (take) begin
               best_idx_in  = idx_ff;
               best_prio_in = rd_prio;
               best_val_in  = rd_value;
            end
            if (idx_ff == last_idx) begin
               idx_in   = take ? idx_ff : best_idx_ff;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_SHIFT: begin
            rd_addr = pend_ff ? AW'(idx_ff + CW'(2)) : AW'(idx_ff + CW'(1));
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            if (idx_ff == last_idx) begin
               // Compaction done: drop the winner and report it
               count_in      = last_idx;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = best_val_ff;
               rsp_prio_in   = best_prio_ff;
               rsp_status_in = pqs_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end else if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               // Move the next entry down one slot
               wr_en  = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_val_ff   <= best_val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_prio_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Fill level never passes the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   // An accepted enqueue on a non-full queue grows the count by one
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == pqs_pkg::OP_ENQUEUE) && !full
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("enqueue did not grow the count");

   // RAM writes stay inside the occupied region plus the append slot
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("RAM write outside occupied slots");

   // A dequeue on a non-empty queue enters the scan
   a_deq_scan: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == pqs_pkg::OP_DEQUEUE) && (count_ff != '0)
      |=> state_ff == ST_SCAN)
      else $error("dequeue did not start the scan");

endmodule
